/* hw/rtl/cfq_pkg.sv */
package cfq_pkg;

   localparam int DEPTH  = 8;
   localparam int DATA_W = 32;
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   localparam logic [1:0] OP_ENQ  = 2'd0;
   localparam logic [1:0] OP_DEQ  = 2'd1;
   localparam logic [1:0] OP_PEEK = 2'd2;
   localparam logic [1:0] OP_DUMP = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic       enq;        // write word at tail, advance tail, count up
      logic       deq;        // advance head, count down
      logic       rd_start;   // read at head and set up the walk
      logic       rd_all;     // with rd_start: walk over every stored entry
      logic       rd_next;    // read at the walk pointer
      logic       load_out;   // load the result register
      logic       out_from_mem;
      logic [1:0] out_status;
   } dp_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic out_last;
   } dp_stat_type;

endpackage

/* hw/rtl/circular_fifo_queue_core.sv */
// Enqueue, and any item that meets a full or empty queue, gives its result in the cycle after
// acceptance; dequeue and peek give theirs through the registered store read and the result register.
// A dump gives its words one by one and reads the next word only after the consumer accepts the last.
// One item is handled at a time: the next is accepted in the cycle after its last result is taken.
// Reset clears the head, tail and count (queue empty); the store contents stay undefined.
module circular_fifo_queue_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_operation,
   input  logic signed [cfq_pkg::DATA_W-1:0] req_data_in,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [cfq_pkg::DATA_W-1:0] rsp_data_out,
   output logic [1:0]                        rsp_status,
   output logic                              rsp_last
);

   cfq_pkg::dp_cmd_type  cmd;
   cfq_pkg::dp_stat_type stat;

   cfq_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .cmd           (cmd),
      .stat          (stat)
   );

   cfq_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .req_data_in  (req_data_in),
      .cmd          (cmd),
      .stat         (stat),
      .rsp_data_out (rsp_data_out),
      .rsp_status   (rsp_status),
      .rsp_last     (rsp_last)
   );

endmodule

/* hw/rtl/cfq_ctrl.sv */
module cfq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_operation,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output cfq_pkg::dp_cmd_type  cmd,
   input  cfq_pkg::dp_stat_type stat
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_RESP = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [1:0] op_ff, op_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff    <= cfq_pkg::OP_ENQ;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      op_in     = op_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in = req_operation;
               if (req_operation == cfq_pkg::OP_ENQ) begin
                  cmd.load_out   = 1'b1;
                  cmd.enq        = !stat.full;
                  cmd.out_status = stat.full ? cfq_pkg::ST_FULL : cfq_pkg::ST_OK;
                  state_in       = S_RESP;
               end else if (stat.empty) begin
                  cmd.load_out   = 1'b1;
                  cmd.out_status = cfq_pkg::ST_EMPTY;
                  state_in       = S_RESP;
               end else begin
                  cmd.rd_start = 1'b1;
                  cmd.rd_all   = (req_operation == cfq_pkg::OP_DUMP);
                  state_in     = S_READ;
               end
            end
         end
         S_READ: begin
            // The registered memory word is ready in this cycle.
            cmd.load_out     = 1'b1;
            cmd.out_from_mem = 1'b1;
            cmd.out_status   = cfq_pkg::ST_OK;
            cmd.deq          = (op_ff == cfq_pkg::OP_DEQ);
            state_in         = S_RESP;
         end
         S_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (stat.out_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.rd_next = 1'b1;
                  state_in    = S_READ;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

/* hw/rtl/cfq_dpath.sv */
module cfq_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic signed [cfq_pkg::DATA_W-1:0]   req_data_in,
   input  cfq_pkg::dp_cmd_type                 cmd,
   output cfq_pkg::dp_stat_type                stat,
   output logic signed [cfq_pkg::DATA_W-1:0]   rsp_data_out,
   output logic [1:0]                          rsp_status,
   output logic                                rsp_last
);

   localparam logic [cfq_pkg::IDX_W-1:0] IDX_LAST = cfq_pkg::IDX_W'(cfq_pkg::DEPTH - 1);
   localparam logic [cfq_pkg::CNT_W-1:0] CNT_FULL = cfq_pkg::CNT_W'(cfq_pkg::DEPTH);
   localparam logic [cfq_pkg::CNT_W-1:0] CNT_ONE  = cfq_pkg::CNT_W'(1);

   logic [cfq_pkg::DATA_W-1:0] store_ff [cfq_pkg::DEPTH];
   logic [cfq_pkg::DATA_W-1:0] rd_data_ff;

   logic [cfq_pkg::IDX_W-1:0] head_ff, head_in;
   logic [cfq_pkg::IDX_W-1:0] tail_ff, tail_in;
   logic [cfq_pkg::IDX_W-1:0] walk_ff, walk_in;
   logic [cfq_pkg::CNT_W-1:0] count_ff, count_in;
   logic [cfq_pkg::CNT_W-1:0] left_ff, left_in;

   logic signed [cfq_pkg::DATA_W-1:0] data_ff, data_in;
   logic [1:0]                        status_ff, status_in;
   logic                              last_ff, last_in;

   logic [cfq_pkg::IDX_W-1:0] rd_addr;
   logic                      rd_en;

   function automatic logic [cfq_pkg::IDX_W-1:0] wrap_next(
      input logic [cfq_pkg::IDX_W-1:0] idx
   );
      return (idx == IDX_LAST) ? '0 : idx + 1'b1;
   endfunction

   assign rd_addr = cmd.rd_start ? head_ff : walk_ff;
   assign rd_en   = cmd.rd_start | cmd.rd_next;

   // Entry store: one write port at the tail, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.enq) begin
         store_ff[tail_ff] <= req_data_in;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      walk_in   = walk_ff;
      count_in  = count_ff;
      left_in   = left_ff;
      data_in   = data_ff;
      status_in = status_ff;
      last_in   = last_ff;

      if (cmd.enq) begin
         tail_in  = wrap_next(tail_ff);
         count_in = count_ff + 1'b1;
      end else if (cmd.deq) begin
         head_in  = wrap_next(head_ff);
         count_in = count_ff - 1'b1;
      end

      if (rd_en) begin
         walk_in = wrap_next(rd_addr);
      end
      if (cmd.rd_start) begin
         left_in = cmd.rd_all ? count_ff : CNT_ONE;
      end

      if (cmd.load_out) begin
         status_in = cmd.out_status;
         if (cmd.out_from_mem) begin
            data_in = rd_data_ff;
            last_in = (left_ff == CNT_ONE);
            left_in = left_ff - 1'b1;
         end else begin
            data_in = '0;
            last_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_ff   <= walk_in;
      left_ff   <= left_in;
      data_ff   <= data_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   assign stat.full     = (count_ff == CNT_FULL);
   assign stat.empty    = (count_ff == '0);
   assign stat.out_last = last_ff;

   assign rsp_data_out = data_ff;
   assign rsp_status   = status_ff;
   assign rsp_last     = last_ff;

endmodule
